@@ rtl/imu_pkg.sv @@
`default_nettype none

package imu_pkg;

  localparam int unsigned PktLen   = 28;
  localparam int unsigned SumLen   = 26;
  localparam int unsigned CntW     = 5;
  localparam int unsigned WordAw   = 4;
  localparam int unsigned RamAw    = WordAw + 1;
  localparam int unsigned RamDepth = 2 ** RamAw;
  localparam int unsigned NumWords = 13;

  localparam logic [15:0] WrapLow  = 16'd500;
  localparam logic [15:0] WrapHigh = 16'd59500;

  // captured word slots, packet word index minus one
  localparam int unsigned WId    = 0;
  localparam int unsigned WAng   = 1;
  localparam int unsigned WRate  = 4;
  localparam int unsigned WAccel = 7;
  localparam int unsigned WBat   = 10;
  localparam int unsigned WStamp = 11;
  localparam int unsigned WSum   = 12;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StStamp = 2'd1;
  localparam logic [1:0] StSum   = 2'd2;

  typedef struct packed {
    logic [2:0]         pad;
    logic [1:0]         status;
    logic [15:0]        stamp;
    logic [15:0]        battery_level;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
    logic signed [15:0] rate_z;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_x;
    logic signed [16:0] yaw_rel;
    logic signed [16:0] pitch_rel;
    logic signed [16:0] roll_rel;
  } result_t;

  localparam int unsigned OutBits = $bits(result_t);

endpackage

`default_nettype wire

@@ rtl/imu_packet_parser.sv @@
// Sensor packet receiver.
// Input stream: one word per serial byte. s_axis_tuser = 0 carries a data byte
// in s_axis_tdata; s_axis_tuser = 1 is a recalibrate command that copies the
// angles of the last good packet into the zero angles.
// Every 28 data bytes form one packet. Byte pairs are stored as 16-bit words
// in a two-bank packet RAM; the bank flips after each packet, so the next
// packet streams in at one byte per cycle while the finished one is read back.
// Readout takes 13 RAM reads in S_READ, then S_LAST captures the last word
// and S_COMMIT registers the result onto the master stream once the output
// register is free.
// Packets with a foreign id give no result; a checksum mismatch gives a
// result with status 2 and all other fields zero.
// Sustained rate is one byte per cycle. The input stalls only while a readout
// is still pending: for the last byte of the next packet and for a
// recalibrate word, which both wait for the commit of the previous packet.
// The commit waits while the output register holds a result the receiver has
// not taken, so a stalled receiver eventually stalls the input.
// Reset clears the byte counter, checksum, zero and last angles, last stamp
// and the device id; the packet RAM needs no clearing.
`default_nettype none

module imu_packet_parser (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [7:0]                   cfg_wdata_i,   // device_id
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // data_byte
  input  wire logic                         s_axis_tuser,  // mode
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // roll_rel, pitch_rel, yaw_rel, rate_x, rate_y, rate_z, accel_x, accel_y,
  // accel_z, battery_level, stamp, status, zero fill
  output logic [imu_pkg::OutBits-1:0]       m_axis_tdata
);

  import imu_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_LAST, S_COMMIT} state_e;

  localparam logic [CntW-1:0]   LastByte = CntW'(PktLen - 1);
  localparam logic [CntW-1:0]   SumEnd   = CntW'(SumLen);
  localparam logic [WordAw-1:0] LastRd   = WordAw'(NumWords - 1);

  state_e            state_q;
  logic [CntW-1:0]   byte_cnt_q;
  logic              bank_q, rd_bank_q;
  logic [7:0]        hi_q;
  logic [15:0]       sum_q, sum_cap_q;
  logic [7:0]        dev_id_q;
  logic [WordAw-1:0] rd_idx_q, cap_idx_q;
  logic              rd_vld_q;
  logic [15:0]       cap_q [NumWords];
  logic [15:0]       zero_q [3];
  logic [15:0]       last_q [3];
  logic [15:0]       last_stamp_q;
  logic              zero_valid_q;
  logic              m_valid_q;
  result_t           out_q, out_d;

  logic              in_fire, data_fire, recal_fire, last_byte;
  logic              ram_we, ram_re;
  logic [RamAw-1:0]  ram_waddr, ram_raddr;
  logic [15:0]       ram_rdata;
  logic              commit, id_ok, sum_ok, stamp_fail;
  logic [15:0]       zero_eff [3];
  logic [16:0]       rel [3];
  logic [15:0]       pkt_stamp;

  assign last_byte     = byte_cnt_q == LastByte;
  assign s_axis_tready = (state_q == S_IDLE) || (!s_axis_tuser && !last_byte);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign data_fire     = in_fire && !s_axis_tuser;
  assign recal_fire    = in_fire && s_axis_tuser;

  assign ram_we    = data_fire && byte_cnt_q[0];
  assign ram_waddr = {bank_q, byte_cnt_q[CntW-1:1]};
  assign ram_re    = state_q == S_READ;
  assign ram_raddr = {rd_bank_q, rd_idx_q + WordAw'(1)};

  imu_ram #(
    .Width (16),
    .Depth (RamDepth)
  ) u_pkt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({hi_q, s_axis_tdata}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign commit     = (state_q == S_COMMIT) && (!m_valid_q || m_axis_tready);
  assign id_ok      = cap_q[WId][7:0] == dev_id_q;
  assign sum_ok     = cap_q[WSum] == sum_cap_q;
  assign pkt_stamp  = cap_q[WStamp];
  assign stamp_fail = (last_stamp_q != 16'd0) && (pkt_stamp < last_stamp_q) &&
                      !((pkt_stamp < WrapLow) && (last_stamp_q > WrapHigh));

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      zero_eff[k] = zero_valid_q ? zero_q[k] : cap_q[WAng+k];
      rel[k]      = {cap_q[WAng+k][15], cap_q[WAng+k]} - {zero_eff[k][15], zero_eff[k]};
    end
  end

  always_comb begin
    out_d = '0;
    if (sum_ok) begin
      out_d.roll_rel      = rel[0];
      out_d.pitch_rel     = rel[1];
      out_d.yaw_rel       = rel[2];
      out_d.rate_x        = cap_q[WRate];
      out_d.rate_y        = cap_q[WRate+1];
      out_d.rate_z        = cap_q[WRate+2];
      out_d.accel_x       = cap_q[WAccel];
      out_d.accel_y       = cap_q[WAccel+1];
      out_d.accel_z       = cap_q[WAccel+2];
      out_d.battery_level = cap_q[WBat];
      out_d.stamp         = pkt_stamp;
      out_d.status        = stamp_fail ? StStamp : StOk;
    end else begin
      out_d.status = StSum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      byte_cnt_q   <= '0;
      bank_q       <= 1'b0;
      rd_bank_q    <= 1'b0;
      sum_q        <= '0;
      sum_cap_q    <= '0;
      dev_id_q     <= '0;
      rd_idx_q     <= '0;
      rd_vld_q     <= 1'b0;
      last_stamp_q <= '0;
      zero_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        zero_q[k] <= '0;
        last_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        dev_id_q <= cfg_wdata_i;
      end

      // byte intake
      if (data_fire) begin
        if (byte_cnt_q < SumEnd) begin
          sum_q <= sum_q + 16'(s_axis_tdata);
        end
        if (last_byte) begin
          byte_cnt_q <= '0;
          sum_q      <= '0;
          sum_cap_q  <= sum_q;
          bank_q     <= ~bank_q;
        end else begin
          byte_cnt_q <= byte_cnt_q + CntW'(1);
        end
      end

      // readout sequencer
      rd_vld_q <= state_q == S_READ;
      case (state_q)
        S_IDLE: begin
          if (data_fire && last_byte) begin
            state_q   <= S_READ;
            rd_idx_q  <= '0;
            rd_bank_q <= bank_q;
          end
        end
        S_READ: begin
          rd_idx_q <= rd_idx_q + WordAw'(1);
          if (rd_idx_q == LastRd) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          if (commit) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (recal_fire) begin
        zero_q       <= last_q;
        zero_valid_q <= 1'b1;
      end

      if (commit && id_ok && sum_ok) begin
        for (int k = 0; k < 3; k++) begin
          last_q[k] <= cap_q[WAng+k];
          zero_q[k] <= zero_eff[k];
        end
        zero_valid_q <= 1'b1;
        if (!stamp_fail) begin
          last_stamp_q <= pkt_stamp;
        end
      end

      if (commit && id_ok) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_fire && !byte_cnt_q[0]) begin
      hi_q <= s_axis_tdata;
    end
    cap_idx_q <= rd_idx_q;
    if (rd_vld_q) begin
      cap_q[cap_idx_q] <= ram_rdata;
    end
    if (commit && id_ok) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  a_last_byte_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_fire && last_byte) |-> (state_q == S_IDLE))
    else $error("packet finished while readout busy");

  a_recal_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    recal_fire |-> (state_q == S_IDLE))
    else $error("recalibrate taken while readout busy");

  a_cap_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT) |-> !rd_vld_q)
    else $error("commit before all words captured");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_cnt_q <= LastByte)
    else $error("byte counter out of range");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |=> (m_valid_q && $stable(out_q)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ rtl/imu_ram.sv @@
`default_nettype none

module imu_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
